/* rtl/cek_pkg.sv */
// Shared constants and arithmetic helpers for the complete elliptic K/E unit.
// Polynomial coefficients (Q30), log constants, stage widths.
// No dependencies.
package cek_pkg;

    localparam int XW   = 31;  // x = 1 - k2 in Q30, range [1, 2^30]
    localparam int HW   = 31;  // Horner accumulator
    localparam int NSQ  = 28;  // log2 fraction bits, one squaring per stage
    localparam int FRW  = 28;
    localparam int SHW  = 5;   // normalization shift 0..30
    localparam int L2W  = 33;  // log2 in Q28
    localparam int LNW  = 33;  // ln in Q28
    localparam int OW   = 32;
    localparam int LAST = 32;  // last stage before the output register

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // round(d * 1e-11 * 2^30)
    function automatic logic [63:0] qc(input logic [63:0] d);
        return (d * 64'd524288 + 64'd24414062) / 64'd48828125;
    endfunction

    typedef logic [HW-1:0] t_coef [0:4];

    localparam t_coef POLY_A = '{
        HW'(qc(64'd138629436112)), HW'(qc(64'd9666344259)), HW'(qc(64'd3590092383)),
        HW'(qc(64'd3742563713)), HW'(qc(64'd1451196212))};
    localparam t_coef POLY_B = '{
        HW'(64'd536870912), HW'(qc(64'd12498593597)), HW'(qc(64'd6880248576)),
        HW'(qc(64'd3328355346)), HW'(qc(64'd441787012))};
    localparam t_coef POLY_C = '{
        HW'(64'd1073741824), HW'(qc(64'd44325141463)), HW'(qc(64'd6260601220)),
        HW'(qc(64'd4757383546)), HW'(qc(64'd1736506451))};
    localparam t_coef POLY_D = '{
        HW'(64'd0), HW'(qc(64'd24998368310)), HW'(qc(64'd9200180037)),
        HW'(qc(64'd4069697526)), HW'(qc(64'd526449639))};

    // one Horner step: c + ((h * x) >> 30), truncated
    function automatic logic [HW-1:0] horner_step(input logic [HW-1:0] c,
                                                  input logic [HW-1:0] h,
                                                  input logic [XW-1:0] x);
        logic [HW+XW-1:0] p;
        p = (HW+XW)'(h) * (HW+XW)'(x);
        return c + HW'(p >> 30);
    endfunction

    // shift that brings the leading one of x to bit 30
    function automatic logic [SHW-1:0] norm_shift(input logic [XW-1:0] x);
        logic [SHW-1:0] s;
        s = SHW'(30);
        for (int i = 0; i < XW; i++) begin
            if (x[i]) begin
                s = SHW'(30 - i);
            end
        end
        return s;
    endfunction

endpackage

/* rtl/complete_elliptic_k_e_unit.sv */
// Top level of the complete elliptic integral unit (K and E from k^2).
// Fully pipelined Horner polynomials plus a squaring-chain log2.
// Depends on cek_pkg.
//
// Usage:
//   A word is taken at each rising edge with start high and busy low. busy
//   is tied low: a new k^2 may be presented in every cycle.
//   Each result is shown for exactly one cycle with o_valid high.
//   Results leave in input order.
//   Throughput is one word per cycle; the pipeline depth is set by
//   the log2 path: leading-one normalization, 28 squaring stages (one
//   fraction bit each), two stages for the ln2 scaling, one product stage
//   and the final add/saturate. The four Horner chains run alongside.
//   k^2 below zero or at/above 1.0 gives zero integrals and o_range_error.
//   Outputs are Q5.27 and saturate at all ones.
//   Reset (synchronous, active low) clears the valid bits of every stage;
//   words in flight are dropped. The receiver cannot stall the block.
module complete_elliptic_k_e_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_k_squared,
    output logic        o_valid,
    output logic [31:0] o_integral_first_kind,
    output logic [31:0] o_integral_second_kind,
    output logic        o_range_error
);

    localparam int XW   = cek_pkg::XW;
    localparam int HW   = cek_pkg::HW;
    localparam int NSQ  = cek_pkg::NSQ;
    localparam int FRW  = cek_pkg::FRW;
    localparam int SHW  = cek_pkg::SHW;
    localparam int L2W  = cek_pkg::L2W;
    localparam int LNW  = cek_pkg::LNW;
    localparam int OW   = cek_pkg::OW;
    localparam int LAST = cek_pkg::LAST;

    logic            r_v   [0:LAST];
    logic            r_err [0:LAST];
    logic [XW-1:0]   r_x   [0:3];
    logic [XW-1:0]   r_m   [0:NSQ];
    logic [FRW-1:0]  r_fr  [1:NSQ];
    logic [SHW-1:0]  r_sh  [1:NSQ+1];
    logic [HW-1:0]   r_ha  [1:LAST];
    logic [HW-1:0]   r_hb  [1:LAST];
    logic [HW-1:0]   r_hc  [1:LAST];
    logic [HW-1:0]   r_hd  [1:LAST];
    logic [46:0]     r_phi;
    logic [45:0]     r_plo;
    logic [LNW-1:0]  r_ln;
    logic [47:0]     r_qbh, r_qdh;
    logic [46:0]     r_qbl, r_qdl;

    logic [L2W-1:0]  l2;
    logic [63:0]     ln_sum;
    logic [63:0]     tb_sum, td_sum;
    logic [33:0]     k_sum, e_sum;

    assign busy = 1'b0;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r_v[0] <= start;
            for (int k = 1; k <= LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
            o_valid <= r_v[LAST];
        end
    end

    // input stage, error line, x line
    always_ff @(posedge i_clk) begin
        r_err[0] <= i_k_squared[31] | i_k_squared[30];
        r_x[0]   <= XW'(33'h040000000 - {1'b0, i_k_squared});
        for (int k = 1; k <= LAST; k++) begin
            r_err[k] <= r_err[k-1];
        end
        for (int k = 1; k <= 3; k++) begin
            r_x[k] <= r_x[k-1];
        end
    end

    // normalization
    always_ff @(posedge i_clk) begin
        r_sh[1] <= cek_pkg::norm_shift(r_x[0]);
        r_m[0]  <= r_x[0] << cek_pkg::norm_shift(r_x[0]);
        for (int k = 2; k <= NSQ + 1; k++) begin
            r_sh[k] <= r_sh[k-1];
        end
    end

    // squaring chain: one fraction bit of log2 per stage
    for (genvar k = 1; k <= NSQ; k++) begin : g_sq
        logic [2*XW-1:0] sq;
        logic [31:0]     t;
        logic [FRW-1:0]  fr_prev;
        assign sq = (2*XW)'(r_m[k-1]) * (2*XW)'(r_m[k-1]);
        assign t  = 32'(sq >> 30);
        if (k == 1) begin : g_first
            assign fr_prev = '0;
        end else begin : g_rest
            assign fr_prev = r_fr[k-1];
        end
        always_ff @(posedge i_clk) begin
            r_m[k]  <= t[31] ? t[31:1] : t[30:0];
            r_fr[k] <= {fr_prev[FRW-2:0], t[31]};
        end
    end

    // Horner chains, step j in stage j, then carried along
    always_ff @(posedge i_clk) begin
        r_ha[1] <= cek_pkg::horner_step(cek_pkg::POLY_A[3], cek_pkg::POLY_A[4], r_x[0]);
        r_hb[1] <= cek_pkg::horner_step(cek_pkg::POLY_B[3], cek_pkg::POLY_B[4], r_x[0]);
        r_hc[1] <= cek_pkg::horner_step(cek_pkg::POLY_C[3], cek_pkg::POLY_C[4], r_x[0]);
        r_hd[1] <= cek_pkg::horner_step(cek_pkg::POLY_D[3], cek_pkg::POLY_D[4], r_x[0]);
        for (int j = 2; j <= 4; j++) begin
            r_ha[j] <= cek_pkg::horner_step(cek_pkg::POLY_A[4-j], r_ha[j-1], r_x[j-1]);
            r_hb[j] <= cek_pkg::horner_step(cek_pkg::POLY_B[4-j], r_hb[j-1], r_x[j-1]);
            r_hc[j] <= cek_pkg::horner_step(cek_pkg::POLY_C[4-j], r_hc[j-1], r_x[j-1]);
            r_hd[j] <= cek_pkg::horner_step(cek_pkg::POLY_D[4-j], r_hd[j-1], r_x[j-1]);
        end
        for (int j = 5; j <= LAST; j++) begin
            r_ha[j] <= r_ha[j-1];
            r_hb[j] <= r_hb[j-1];
            r_hc[j] <= r_hc[j-1];
            r_hd[j] <= r_hd[j-1];
        end
    end

    // log2 -> ln, split product over two stages; then the B and D chains times ln
    assign l2     = {r_sh[NSQ+1], {FRW{1'b0}}} - L2W'(r_fr[NSQ]);
    assign ln_sum = {1'b0, r_phi, 16'd0} + 64'(r_plo);

    always_ff @(posedge i_clk) begin
        r_phi <= 47'(l2[32:16]) * 47'(cek_pkg::LN2_Q30);
        r_plo <= 46'(l2[15:0]) * 46'(cek_pkg::LN2_Q30);
        r_ln  <= ln_sum[62:30];
        r_qbh <= 48'(r_hb[LAST-1]) * 48'(r_ln[32:16]);
        r_qbl <= 47'(r_hb[LAST-1]) * 47'(r_ln[15:0]);
        r_qdh <= 48'(r_hd[LAST-1]) * 48'(r_ln[32:16]);
        r_qdl <= 47'(r_hd[LAST-1]) * 47'(r_ln[15:0]);
    end

    // final add and saturate
    assign tb_sum = {r_qbh, 16'd0} + 64'(r_qbl);
    assign td_sum = {r_qdh, 16'd0} + 64'(r_qdl);
    assign k_sum  = 34'(r_ha[LAST] >> 3) + 34'(tb_sum[63:31]);
    assign e_sum  = 34'(r_hc[LAST] >> 3) + 34'(td_sum[63:31]);

    always_ff @(posedge i_clk) begin
        o_range_error <= r_err[LAST];
        if (r_err[LAST]) begin
            o_integral_first_kind  <= '0;
            o_integral_second_kind <= '0;
        end else begin
            o_integral_first_kind  <= (k_sum[33:32] != 2'b00) ? {OW{1'b1}} : k_sum[31:0];
            o_integral_second_kind <= (e_sum[33:32] != 2'b00) ? {OW{1'b1}} : e_sum[31:0];
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
            (o_integral_first_kind == '0 && o_integral_second_kind == '0))
        else $error("range error word with nonzero integrals");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 34))
        else $error("result strobe without matching start");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !r_err[0]) |-> (r_x[0] != '0 && r_x[0] <= XW'(32'h40000000)))
        else $error("x outside (0, 1]");

    // out-of-range words may carry x = 0, so only valid words are checked
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !r_err[1]) |-> r_m[0][XW-1])
        else $error("mantissa not normalized");

endmodule

/* test/tb.sv */
// Testbench for complete_elliptic_k_e_unit: directed and random k^2 words,
// each checked against a local bit-exact predictor of K and E.
// Depends on the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] k_int;
        logic [31:0] e_int;
        logic        rerr;
    } t_ke;

    class ke_scoreboard;
        t_ke pending[$];
        int  errors = 0;
        int  n_checked = 0;
        int  n_range = 0;

        function logic [63:0] coef(input logic [63:0] d);
            return (d * 64'd524288 + 64'd24414062) / 64'd48828125;
        endfunction

        function logic [63:0] poly(input logic [63:0] c0, input logic [63:0] c1,
                                   input logic [63:0] c2, input logic [63:0] c3,
                                   input logic [63:0] c4, input logic [63:0] x);
            logic [63:0] h;
            h = c4;
            h = c3 + ((h * x) >> 30);
            h = c2 + ((h * x) >> 30);
            h = c1 + ((h * x) >> 30);
            h = c0 + ((h * x) >> 30);
            return h;
        endfunction

        // ln(2^30/x) in Q28
        function logic [63:0] ln_inv(input logic [63:0] x);
            int          lead;
            logic [63:0] m, fr, l2;
            lead = 30;
            fr = 0;
            while (lead > 0 && x[lead] == 1'b0) lead--;
            m = x << (30 - lead);
            for (int i = 0; i < 28; i++) begin
                m = (m * m) >> 30;
                fr = fr << 1;
                if (m >= 64'd2147483648) begin
                    fr = fr | 1;
                    m = m >> 1;
                end
            end
            l2 = (64'(30 - lead) << 28) - fr;
            return (l2 * 64'd744261118) >> 30;
        endfunction

        function logic [31:0] merge(input logic [63:0] lin, input logic [63:0] lg,
                                    input logic [63:0] ln);
            logic [63:0] v;
            v = (lin >> 3) + ((lg * ln) >> 31);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void note_input(input logic [31:0] k2);
            t_ke         r;
            logic [63:0] x, ln;
            if (k2 >= 32'd1073741824) begin
                r.k_int = 0; r.e_int = 0; r.rerr = 1'b1;
            end else begin
                x = 64'd1073741824 - 64'(k2);
                ln = ln_inv(x);
                r.k_int = merge(poly(coef(64'd138629436112), coef(64'd9666344259),
                    coef(64'd3590092383), coef(64'd3742563713), coef(64'd1451196212), x),
                    poly(64'd536870912, coef(64'd12498593597), coef(64'd6880248576),
                    coef(64'd3328355346), coef(64'd441787012), x), ln);
                r.e_int = merge(poly(64'd1073741824, coef(64'd44325141463),
                    coef(64'd6260601220), coef(64'd4757383546), coef(64'd1736506451), x),
                    poly(64'd0, coef(64'd24998368310), coef(64'd9200180037),
                    coef(64'd4069697526), coef(64'd526449639), x), ln);
                r.rerr = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(input logic [31:0] k_int, input logic [31:0] e_int,
                                   input logic rerr);
            t_ke w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word K=%h E=%h err=%b", $time, k_int, e_int, rerr);
                errors++;
                return;
            end
            w = pending.pop_front();
            n_checked++;
            if (rerr) n_range++;
            if (k_int !== w.k_int) begin
                $display("%0t: K expected %h actual %h", $time, w.k_int, k_int);
                errors++;
            end
            if (e_int !== w.e_int) begin
                $display("%0t: E expected %h actual %h", $time, w.e_int, e_int);
                errors++;
            end
            if (rerr !== w.rerr) begin
                $display("%0t: range_error expected %b actual %b", $time, w.rerr, rerr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_k_squared = '0;
    logic        busy, o_valid, o_range_error;
    logic [31:0] o_integral_first_kind, o_integral_second_kind;

    ke_scoreboard sb = new();
    int idle_cycles = 0;
    bit calm = 1'b0;  // no idling while set

    complete_elliptic_k_e_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_k_squared(i_k_squared), .o_valid(o_valid),
        .o_integral_first_kind(o_integral_first_kind),
        .o_integral_second_kind(o_integral_second_kind),
        .o_range_error(o_range_error));

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_input(i_k_squared);
            if (o_valid) begin
                sb.check_result(o_integral_first_kind, o_integral_second_kind,
                                o_range_error);
            end
            if ((start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("watchdog: no progress");
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // present one word, hold until taken; unless calm is set, start may drop for idle cycles first
    task automatic send_word(input logic [31:0] k2);
        while (!calm && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_k_squared <= k2;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_k2();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return $urandom_range(32'h3FFF_FFFF);
        if (sel == 6) return 32'h4000_0000 - $urandom_range(4096); // near one
        if (sel == 7) return $urandom_range(4096);                 // near zero
        if (sel == 8) return $urandom() >> $urandom_range(31);
        return $urandom();                                         // mostly invalid
    endfunction

    initial begin
        logic [31:0] directed [$];
        int          wait_cnt;
        directed = {32'h0, 32'h1, 32'h2, 32'h3FFF_FFFF, 32'h3FFF_FFFE,
                    32'h4000_0000, 32'h4000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h2000_0000, 32'h3000_0000, 32'h1000_0000,
                    32'h3FFF_0000, 32'h3F00_0000, 32'h0000_FFFF, 32'h1555_5555,
                    32'h2AAA_AAAA, 32'hC000_0000, 32'h5555_5555};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_word(directed[i]);
        for (int n = 0; n < 1750; n++) begin
            calm = (n >= 600 && n < 900);
            send_word(rand_k2());
        end
        start <= 1'b0;
        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (40) @(posedge i_clk);
        $display("checked %0d results, %0d of them range errors",
                 sb.n_checked, sb.n_range);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
